// ===== rtl/nafsk_pkg.sv =====
// shared types, constants and the sine table of the afsk tone modulator
package nafsk_pkg;

  // sine table geometry
  localparam int SINE_DEPTH   = 16;
  localparam int SINE_IDX_W   = $clog2(SINE_DEPTH);
  localparam int SAMPLE_IDX_W = $clog2(2 * SINE_DEPTH);

  // field widths
  localparam int LEVEL_W    = 4;
  localparam int DATA_W     = 8;
  localparam int TICK_W     = 8;
  localparam int BIT_POS_W  = $clog2(DATA_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // samples per bit for each tone
  localparam logic [SAMPLE_IDX_W-1:0] SAMPLES_LOW  = SAMPLE_IDX_W'(SINE_DEPTH);
  localparam logic [SAMPLE_IDX_W-1:0] SAMPLES_HIGH = SAMPLE_IDX_W'(2 * SINE_DEPTH - 1);

  // last bit of a byte
  localparam logic [BIT_POS_W-1:0] LAST_BIT_POS = BIT_POS_W'(DATA_W - 1);

  // register reset values
  localparam logic [TICK_W-1:0] LOW_TICKS_RST  = 8'd42;
  localparam logic [TICK_W-1:0] HIGH_TICKS_RST = 8'd28;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TICKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS = 1'b1;

  // one period of the sine wave, 4-bit dac codes
  localparam logic [LEVEL_W-1:0] SINE_TABLE [SINE_DEPTH] = '{
    4'd7, 4'd10, 4'd13, 4'd14, 4'd15, 4'd14, 4'd13, 4'd10,
    4'd7, 4'd5,  4'd2,  4'd1,  4'd0,  4'd1,  4'd2,  4'd5
  };

  // classified input item
  typedef struct packed {
    logic              is_tick;
    logic [DATA_W-1:0] data_byte;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [LEVEL_W-1:0] dac_level;
    logic               tone_high;
    logic               byte_done;
  } res_t;

  // back end status toward the top level
  typedef struct packed {
    logic busy;
    logic cmd_pop;
    logic res_push;
  } back_status_t;

endpackage

// ===== rtl/nafsk_front.sv =====
// front end: accepts input transfers, classifies them and queues commands
module nafsk_front import nafsk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              opcode_i,
  input  logic [DATA_W-1:0] data_byte_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;
  cmd_t       cmd_in;

  // classify the incoming item
  always_comb begin
    cmd_in.is_tick   = (opcode_i == OP_TICK);
    cmd_in.data_byte = data_byte_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign wr_en       = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // command storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/nafsk_back.sv =====
// back end: nrzi tone state, sample timing and sine lookup
module nafsk_back import nafsk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  input  logic                  res_space_i,
  output res_t                  res_o,
  output back_status_t          status_o
);

  logic [TICK_W-1:0]       low_ticks_q, low_ticks_d;
  logic [TICK_W-1:0]       high_ticks_q, high_ticks_d;
  logic [DATA_W-1:0]       shift_q, shift_d;
  logic [BIT_POS_W-1:0]    bit_pos_q, bit_pos_d;
  logic                    tone_q, tone_d;
  logic [SAMPLE_IDX_W-1:0] sample_idx_q, sample_idx_d;
  logic [TICK_W-1:0]       tick_q, tick_d;
  logic                    busy_q, busy_d;

  logic                    take;
  logic [TICK_W-1:0]       period;
  logic                    last_tick;
  logic                    last_sample;
  logic [SAMPLE_IDX_W-1:0] samples;
  logic [BIT_POS_W-1:0]    next_pos;
  logic                    res_push;
  logic                    done;

  // a command leaves the queue only when a result slot is free
  assign take = cmd_valid_i && res_space_i;

  // sample period and end of sample / end of bit detection
  always_comb begin
    period      = tone_q ? high_ticks_q : low_ticks_q;
    if (period == '0) begin
      period = TICK_W'(1);
    end
    samples     = tone_q ? SAMPLES_HIGH : SAMPLES_LOW;
    last_tick   = ({1'b0, tick_q} + 1'b1) >= {1'b0, period};
    last_sample = ({1'b0, sample_idx_q} + 1'b1) >= {1'b0, samples};
    next_pos    = bit_pos_q + 1'b1;
  end

  // command execution
  always_comb begin
    shift_d      = shift_q;
    bit_pos_d    = bit_pos_q;
    tone_d       = tone_q;
    sample_idx_d = sample_idx_q;
    tick_d       = tick_q;
    busy_d       = busy_q;
    res_push     = 1'b0;
    done         = 1'b0;
    if (take) begin
      if (!cmd_i.is_tick && !busy_q) begin
        // start a byte, nrzi on bit 0
        shift_d      = cmd_i.data_byte;
        bit_pos_d    = '0;
        sample_idx_d = '0;
        tick_d       = '0;
        busy_d       = 1'b1;
        tone_d       = tone_q ^ ~cmd_i.data_byte[0];
      end else if (cmd_i.is_tick && busy_q) begin
        res_push = 1'b1;
        if (last_tick) begin
          tick_d = '0;
          if (last_sample) begin
            sample_idx_d = '0;
            if (bit_pos_q == LAST_BIT_POS) begin
              busy_d = 1'b0;
              done   = 1'b1;
            end else begin
              // next bit, a zero toggles the tone
              bit_pos_d = next_pos;
              tone_d    = tone_q ^ ~shift_q[next_pos];
            end
          end else begin
            sample_idx_d = sample_idx_q + 1'b1;
          end
        end else begin
          tick_d = tick_q + 1'b1;
        end
      end
    end
  end

  // configuration writes
  always_comb begin
    low_ticks_d  = low_ticks_q;
    high_ticks_d = high_ticks_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_TICKS:  low_ticks_d  = cfg_data_i;
        REG_HIGH_TICKS: high_ticks_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // table position wraps modulo the table depth (a power of two)
  always_comb begin
    res_o.dac_level = SINE_TABLE[sample_idx_q[SINE_IDX_W-1:0]];
    res_o.tone_high = tone_q;
    res_o.byte_done = done;
  end

  assign status_o.busy     = busy_q;
  assign status_o.cmd_pop  = take;
  assign status_o.res_push = res_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_ticks_q  <= LOW_TICKS_RST;
      high_ticks_q <= HIGH_TICKS_RST;
      shift_q      <= '0;
      bit_pos_q    <= '0;
      tone_q       <= 1'b0;
      sample_idx_q <= '0;
      tick_q       <= '0;
      busy_q       <= 1'b0;
    end else begin
      low_ticks_q  <= low_ticks_d;
      high_ticks_q <= high_ticks_d;
      shift_q      <= shift_d;
      bit_pos_q    <= bit_pos_d;
      tone_q       <= tone_d;
      sample_idx_q <= sample_idx_d;
      tick_q       <= tick_d;
      busy_q       <= busy_d;
    end
  end

endmodule

// ===== rtl/nafsk_res_q.sv =====
// two-entry result queue in front of the output ports
module nafsk_res_q import nafsk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_push_i,
  input  res_t res_i,
  output logic res_space_o,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign res_space_o = (cnt_q != 2'd2);
  assign empty       = (cnt_q == 2'd0);
  assign wr_en       = res_push_i && res_space_o;
  assign rd_en       = pop && !empty;
  assign res_o       = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== rtl/nrzi_afsk_tone_modulator_core.sv =====
// top level of the nrzi afsk tone modulator
// path: an accepted tick is registered in the command queue, and its sample then in the result queue
// throughput: one item per cycle while the result queue has space, set by the tone engine in the back end
// a stalled output backs up through two result slots and two command slots before full rises
// reset: asynchronous active low; idle, low tone, queues empty, registers at 42 and 28 ticks
module nrzi_afsk_tone_modulator_core import nafsk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  opcode_i,
  input  logic [DATA_W-1:0]     data_byte_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [LEVEL_W-1:0]    dac_level_o,
  output logic                  tone_high_o,
  output logic                  byte_done_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic         cmd_valid;
  cmd_t         cmd;
  logic         res_space;
  res_t         res_new;
  res_t         res_head;
  back_status_t status;

  // input side
  nafsk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (status.cmd_pop)
  );

  // tone engine
  nafsk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .res_space_i (res_space),
    .res_o       (res_new),
    .status_o    (status)
  );

  // output side
  nafsk_res_q u_res_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_push_i  (status.res_push),
    .res_i       (res_new),
    .res_space_o (res_space),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_head)
  );

  assign dac_level_o = res_head.dac_level;
  assign tone_high_o = res_head.tone_high;
  assign byte_done_o = res_head.byte_done;

  // a result is only produced into a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.res_push |-> res_space)
    else $error("result produced with the result queue full");

  // results come only from ticks while a byte is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.res_push |-> (status.busy && cmd.is_tick && cmd_valid))
    else $error("result produced outside an active byte");

  // an accepted transfer is visible to the back end on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> cmd_valid)
    else $error("accepted item missing from the command queue");

  // the engine is no longer busy once it has finished a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.busy && status.res_push && res_new.byte_done) |=> !status.busy)
    else $error("engine still busy after the last sample of a byte");

endmodule

// ===== sim/tb.sv =====
// self-checking testbench of the nrzi afsk tone modulator core
module tb;
  import nafsk_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int ITEMS_PER_RUN = 670;

  // clock, reset and block ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  opcode_i = OP_TICK;
  logic [DATA_W-1:0]     data_byte_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [LEVEL_W-1:0]    dac_level_o;
  logic                  tone_high_o;
  logic                  byte_done_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_LOW_TICKS;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // modulator state as the testbench sees it
  logic [TICK_W-1:0]       low_ticks;
  logic [TICK_W-1:0]       high_ticks;
  logic [DATA_W-1:0]       tx_byte;
  logic [BIT_POS_W-1:0]    tx_bit;
  logic                    tx_tone;
  logic [SAMPLE_IDX_W-1:0] tx_sample;
  logic [TICK_W-1:0]       tx_tick;
  logic                    tx_busy;

  // samples still owed by the block, oldest first
  res_t expected_samples[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  nrzi_afsk_tone_modulator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .empty       (empty),
    .pop         (pop),
    .dac_level_o (dac_level_o),
    .tone_high_o (tone_high_o),
    .byte_done_o (byte_done_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // nrzi: a zero bit flips the tone at the start of the bit
  function automatic void apply_nrzi_bit();
    if (!tx_byte[tx_bit]) begin
      tx_tone = ~tx_tone;
    end
  endfunction

  // advance the modulator by one accepted item, queue the sample a tick emits
  function automatic void predict_sample(logic op, logic [DATA_W-1:0] data);
    int   period;
    int   tone_len;
    res_t sample;
    if (op == OP_LOAD) begin
      if (!tx_busy) begin
        tx_byte   = data;
        tx_bit    = '0;
        tx_sample = '0;
        tx_tick   = '0;
        tx_busy   = 1'b1;
        apply_nrzi_bit();
      end
      return;
    end
    if (!tx_busy) begin
      return;
    end
    // table position wraps at the table depth
    sample.dac_level = SINE_TABLE[tx_sample[SINE_IDX_W-1:0]];
    sample.tone_high = tx_tone;
    sample.byte_done = 1'b0;
    period   = tx_tone ? int'(high_ticks) : int'(low_ticks);
    tone_len = tx_tone ? 2 * SINE_DEPTH - 1 : SINE_DEPTH;
    if (period == 0) begin
      period = 1;
    end
    if (int'(tx_tick) + 1 >= period) begin
      tx_tick = '0;
      if (int'(tx_sample) + 1 >= tone_len) begin
        tx_sample = '0;
        if (tx_bit == LAST_BIT_POS) begin
          tx_busy          = 1'b0;
          sample.byte_done = 1'b1;
        end else begin
          tx_bit = tx_bit + 1'b1;
          apply_nrzi_bit();
        end
      end else begin
        tx_sample = tx_sample + 1'b1;
      end
    end else begin
      tx_tick = tx_tick + 1'b1;
    end
    expected_samples.push_back(sample);
  endfunction

  // offer one item, with random idle cycles ahead of it; push stays high after the transfer
  task automatic send_item(logic op, logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    opcode_i    <= op;
    data_byte_i <= data;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    predict_sample(op, data);
  endtask

  // stop offering and wait for every owed sample, then let the pipeline settle
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only called with nothing in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LOW_TICKS:  low_ticks  = value;
      REG_HIGH_TICKS: high_ticks = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // ticks before any load give nothing
  task automatic test_idle_ticks();
    send_item(OP_TICK, 8'hA5);
    send_item(OP_TICK, 8'h5A);
  endtask

  // load of all zeros starts in the high tone, a load while busy is dropped
  task automatic test_load_and_drop();
    send_item(OP_LOAD, 8'h00);
    repeat (4) send_item(OP_TICK, 8'h00);
    send_item(OP_LOAD, 8'hFF);
    repeat (2) send_item(OP_TICK, 8'hFF);
  endtask

  // period cut below the running tick count, zero period, then the widest period
  task automatic test_period_changes();
    wait_drained();
    write_reg(REG_HIGH_TICKS, 8'd3);
    repeat (2) send_item(OP_TICK, 8'h00);
    wait_drained();
    write_reg(REG_HIGH_TICKS, 8'd0);
    write_reg(REG_LOW_TICKS, 8'd0);
    repeat (3) send_item(OP_TICK, 8'h00);
    wait_drained();
    write_reg(REG_LOW_TICKS, 8'd255);
    write_reg(REG_HIGH_TICKS, 8'd255);
    repeat (3) send_item(OP_TICK, 8'h00);
  endtask

  // whole bytes with random content and short periods, plus dropped loads and idle ticks
  task automatic test_random_bytes(int tx_pct, int rx_pct, bit long_hold);
    int counted;
    logic [DATA_W-1:0] payload;
    counted = 0;
    wait_drained();
    send_idle_pct <= tx_pct;
    recv_idle_pct <= rx_pct;
    write_reg(REG_LOW_TICKS, CFG_DATA_W'($urandom_range(1, 3)));
    write_reg(REG_HIGH_TICKS, CFG_DATA_W'($urandom_range(1, 3)));
    if (long_hold) begin
      hold_reqs <= hold_reqs + 1;
    end
    while (counted < ITEMS_PER_RUN) begin
      // finish the byte in progress, now and then a load that must be dropped
      while (tx_busy && counted < ITEMS_PER_RUN) begin
        if ($urandom_range(99) < 4) begin
          send_item(OP_LOAD, DATA_W'($urandom));
        end else begin
          send_item(OP_TICK, DATA_W'($urandom));
          counted++;
        end
        if ($urandom_range(999) == 0) begin
          wait_drained();
        end
      end
      if (counted >= ITEMS_PER_RUN) begin
        break;
      end
      // a few ticks while idle
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 3)) send_item(OP_TICK, DATA_W'($urandom));
      end
      case ($urandom_range(9))
        0:       payload = 8'h00;
        1:       payload = 8'hFF;
        default: payload = DATA_W'($urandom);
      endcase
      send_item(OP_LOAD, payload);
      counted++;
    end
  endtask

  // receiver: random pops, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result transfer with the oldest owed sample
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected sample: dac_level %0d tone_high %0d byte_done %0d",
               dac_level_o, tone_high_o, byte_done_o);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (dac_level_o !== want.dac_level) begin
          $error("dac_level: expected %0d, actual %0d", want.dac_level, dac_level_o);
          mismatches++;
        end
        if (tone_high_o !== want.tone_high) begin
          $error("tone_high: expected %0d, actual %0d", want.tone_high, tone_high_o);
          mismatches++;
        end
        if (byte_done_o !== want.byte_done) begin
          $error("byte_done: expected %0d, actual %0d", want.byte_done, byte_done_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    low_ticks  = LOW_TICKS_RST;
    high_ticks = HIGH_TICKS_RST;
    tx_byte    = '0;
    tx_bit     = '0;
    tx_tone    = 1'b0;
    tx_sample  = '0;
    tx_tick    = '0;
    tx_busy    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_load_and_drop();
    test_period_changes();
    test_random_bytes(37, 53, 1'b1);
    test_random_bytes(53, 37, 1'b0);
    test_random_bytes(0, 0, 1'b1);

    wait_drained();
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nafsk_pkg.sv
rtl/nafsk_front.sv
rtl/nafsk_back.sv
rtl/nafsk_res_q.sv
rtl/nrzi_afsk_tone_modulator_core.sv
sim/tb.sv
